// File: hdl/pdm_pkg.sv
// Shared types and constants for the plus directional movement unit.
// No dependencies; imported by every module of the block.
package pdm_pkg;

  localparam int CFG_W        = 12;
  localparam int CFG_IDX_W    = 1;
  localparam int BAR_W        = 16;
  localparam int OUT_DM_W     = 48;
  localparam int OUT_DATA_W   = OUT_DM_W + BAR_W;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UNSTABLE = 1'b1;

  localparam logic [CFG_W-1:0] PERIOD_RESET   = 12'd14;
  localparam logic [CFG_W-1:0] UNSTABLE_RESET = 12'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic restart;
    logic need_div;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/pdm_div.sv
// Radix-2 restoring divider: one quotient bit per cycle.
// Depends on pdm_pkg for the divisor width.
module pdm_div import pdm_pkg::*; #(
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [CFG_W-1:0] divisor,
  output logic             busy,
  output logic [WIDTH-1:0] quotient
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [CNT_W-1:0] cnt;
  logic [CFG_W-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [CFG_W:0]   shifted;
  logic [CFG_W+1:0] trial;

  assign shifted  = {rem, quo[WIDTH-1]};
  assign trial    = {1'b0, shifted} - {2'b00, divisor};
  assign busy     = (cnt != '0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(WIDTH);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!trial[CFG_W+1]) begin
        rem <= trial[CFG_W-1:0];
        quo <= {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[CFG_W-1:0];
        quo <= {quo[WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hdl/pdm_dpath.sv
// Datapath: configuration, bar registers, +DM, saturating accumulator, output register.
// Depends on pdm_pkg and pdm_div.
module pdm_dpath import pdm_pkg::*; #(
  parameter int PRICE_BITS = 32,
  parameter int ACC_BITS   = 48
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_W-1:0]                      cfg_wdata,
  input  logic                                  s_tuser,
  input  logic [((2*PRICE_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [OUT_DATA_W-1:0]                 m_tdata,
  input  cmd_t                                  cmd,
  output sts_t                                  sts
);

  localparam int SUM_W = ((ACC_BITS > PRICE_BITS) ? ACC_BITS : PRICE_BITS) + 1;
  localparam int CMP_W = BAR_W + 1;

  logic [CFG_W-1:0]      period;
  logic [CFG_W-1:0]      unstable_bars;
  logic                  in_start;
  logic [PRICE_BITS-1:0] in_high;
  logic [PRICE_BITS-1:0] in_low;
  logic [PRICE_BITS-1:0] last_high;
  logic [PRICE_BITS-1:0] last_low;
  logic [ACC_BITS-1:0]   running_dm;
  logic [BAR_W-1:0]      bars_seen;
  logic                  ref_valid;
  logic [PRICE_BITS-1:0] dm_hold;
  logic                  out_valid;
  logic [OUT_DM_W-1:0]   out_dm;
  logic [BAR_W-1:0]      out_bar;

  logic [PRICE_BITS:0]   up;
  logic [PRICE_BITS:0]   down;
  logic [PRICE_BITS-1:0] dm;
  logic [BAR_W-1:0]      bars_inc;
  logic [BAR_W-1:0]      n_sel;
  logic [CFG_W:0]        thr;
  logic                  raw;
  logic                  n_lt_p;
  logic                  n_ge;
  logic                  restart;
  logic                  emit;
  logic                  div_busy;
  logic [ACC_BITS-1:0]   quotient;
  logic [ACC_BITS-1:0]   acc_base;
  logic [PRICE_BITS-1:0] addend;
  logic [SUM_W-1:0]      sum;
  logic [ACC_BITS-1:0]   acc_new;
  logic [ACC_BITS+OUT_DM_W-1:0]   acc_ext;
  logic [PRICE_BITS+OUT_DM_W-1:0] dm_ext;

  assign up       = {1'b0, in_high} - {1'b0, last_high};
  assign down     = {1'b0, last_low} - {1'b0, in_low};
  assign dm       = ($signed(up) > 0 && $signed(up) > $signed(down)) ?
                    up[PRICE_BITS-1:0] : '0;
  assign bars_inc = (bars_seen == '1) ? bars_seen : bars_seen + 1'b1;
  assign n_sel    = cmd.finish ? bars_seen : bars_inc;
  assign thr      = {1'b0, period} + {1'b0, unstable_bars};
  assign raw      = (period < CFG_W'(2));
  assign n_lt_p   = (CMP_W'(bars_inc) < CMP_W'(period));
  assign n_ge     = ((CMP_W'(n_sel) + CMP_W'(1)) >= CMP_W'(thr));
  assign restart  = in_start || !ref_valid;

  assign acc_base = cmd.finish ? running_dm - quotient : running_dm;
  assign addend   = cmd.finish ? dm_hold : dm;
  assign sum      = SUM_W'(acc_base) + SUM_W'(addend);
  assign acc_new  = (|sum[SUM_W-1:ACC_BITS]) ? '1 : sum[ACC_BITS-1:0];
  assign acc_ext  = {{OUT_DM_W{1'b0}}, acc_new};
  assign dm_ext   = {{OUT_DM_W{1'b0}}, dm};

  assign emit = (cmd.eval && !restart && (raw || (n_lt_p && n_ge))) ||
                (cmd.finish && n_ge);

  assign sts.restart  = restart;
  assign sts.need_div = !restart && !raw && !n_lt_p;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_bar, out_dm};

  pdm_div #(
    .WIDTH (ACC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (running_dm),
    .divisor  (period),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      period        <= PERIOD_RESET;
      unstable_bars <= UNSTABLE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PERIOD:   period        <= cfg_wdata;
        REG_UNSTABLE: unstable_bars <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_start <= s_tuser;
      in_high  <= s_tdata[PRICE_BITS-1:0];
      in_low   <= s_tdata[2*PRICE_BITS-1:PRICE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_valid <= 1'b0;
    end else if (cmd.eval && restart) begin
      ref_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      last_high <= in_high;
      last_low  <= in_low;
      dm_hold   <= dm;
      if (restart) begin
        running_dm <= '0;
        bars_seen  <= '0;
      end else begin
        bars_seen <= bars_inc;
        if (!raw && n_lt_p) begin
          running_dm <= acc_new;
        end
      end
    end else if (cmd.finish) begin
      running_dm <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_bar <= n_sel;
      out_dm  <= (cmd.eval && raw) ? dm_ext[OUT_DM_W-1:0] : acc_ext[OUT_DM_W-1:0];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.eval && restart |=> bars_seen == '0 && ref_valid)
    else $error("restart did not open a clean series");

  assert property (@(posedge clk) disable iff (rst)
    emit |-> sts.out_free)
    else $error("result overwrote an item still waiting");

endmodule

// File: hdl/pdm_ctrl.sv
// Controller: sequences accept, evaluate, divide and finish for one bar at a time.
// Depends on pdm_pkg for the state, command and status types.
module pdm_ctrl import pdm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.out_free) state_next = sts.need_div ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (!sts.div_busy) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      ST_EVAL: begin
        cmd.eval      = sts.out_free;
        cmd.div_start = sts.out_free && sts.need_div;
      end
      ST_DIV: ;
      ST_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> sts.div_busy && state == ST_DIV)
    else $error("divider not running after start");

endmodule

// File: hdl/plus_directional_movement_unit.sv
// Top level of the plus directional movement unit: controller plus datapath.
// Depends on pdm_pkg, pdm_ctrl, pdm_dpath (which holds pdm_div).
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  input    | s_tvalid/s_tready  | s_tuser: start_of_series; s_tdata: high, low
//  output   | m_tvalid/m_tready  | m_tdata: plus_dm[47:0], bar_number[63:48]
//  config   | cfg_wr_en          | cfg_index (0 period, 1 unstable_bars), cfg_wdata
//
// A reference, raw or accumulating bar passes through accept and evaluate; a smoothed bar
// also runs the bit-serial divide by period and then finish.
// Reset is synchronous; period returns to 14 and unstable_bars to 0.
// One bar is in flight at a time; a finished item waits in the output register
// while the next bar is accepted, and a stalled output holds the datapath before commit.
module plus_directional_movement_unit import pdm_pkg::*; #(
  parameter int PRICE_BITS = 32,
  parameter int ACC_BITS   = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_W-1:0]                  cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic                              s_tuser,  // start_of_series
  input  logic [((2*PRICE_BITS+7)/8)*8-1:0] s_tdata,  // high, low
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [OUT_DATA_W-1:0]             m_tdata   // plus_dm, bar_number
);

  cmd_t cmd;
  sts_t sts;

  pdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pdm_dpath #(
    .PRICE_BITS (PRICE_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while one is in flight");

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result produced without returning to idle");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for plus_directional_movement_unit: streams price bars and checks
// every +DM output item against an in-bench predictor of the Wilder recurrence.
// Depends on pdm_pkg and the unit's RTL only.
module tb_top;
  import pdm_pkg::*;

  localparam int PRICE_W       = 32;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int HOLD_EVERY    = 250;
  localparam int HOLD_CYCLES   = 400;

  typedef struct {
    logic               start;
    logic [PRICE_W-1:0] high;
    logic [PRICE_W-1:0] low;
  } bar_t;

  typedef struct {
    logic [OUT_DM_W-1:0] plus_dm;
    logic [BAR_W-1:0]    bar_no;
  } dm_out_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_PERIOD;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic                    s_tuser   = 1'b0;
  logic [2*PRICE_W-1:0]    s_tdata   = '0;  // high, low
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;         // plus_dm, bar_number

  plus_directional_movement_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #2 clk = ~clk;

  bar_t    bars_pending[$];
  dm_out_t dm_expected[$];
  int      bars_queued = 0;
  int      fail_count  = 0;
  int      cycle_count = 0;
  int      gap_max     = 0;
  int      stall_max   = 0;

  logic [CFG_W-1:0]    cfg_period   = PERIOD_RESET;
  logic [CFG_W-1:0]    cfg_unstable = UNSTABLE_RESET;
  logic [PRICE_W-1:0]  prev_high    = '0;
  logic [PRICE_W-1:0]  prev_low     = '0;
  logic [OUT_DM_W-1:0] dm_acc       = '0;
  logic [BAR_W-1:0]    bar_count    = '0;
  logic                series_open  = 1'b0;

  function automatic logic [OUT_DM_W-1:0] capped_sum(input logic [OUT_DM_W-1:0] a,
                                                     input logic [OUT_DM_W-1:0] v);
    logic [OUT_DM_W:0] s;
    s = {1'b0, a} + {1'b0, v};
    return s[OUT_DM_W] ? {OUT_DM_W{1'b1}} : s[OUT_DM_W-1:0];
  endfunction

  function automatic bit advance_series(input bar_t b, output dm_out_t r);
    longint up, down;
    logic [OUT_DM_W-1:0] dm;
    r.plus_dm = '0;
    r.bar_no  = '0;
    if (b.start || !series_open) begin
      prev_high   = b.high;
      prev_low    = b.low;
      dm_acc      = '0;
      bar_count   = '0;
      series_open = 1'b1;
      return 1'b0;
    end
    up   = $signed({32'd0, b.high}) - $signed({32'd0, prev_high});
    down = $signed({32'd0, prev_low}) - $signed({32'd0, b.low});
    dm   = (up > 0 && up > down) ? up[OUT_DM_W-1:0] : '0;
    prev_high = b.high;
    prev_low  = b.low;
    if (bar_count != {BAR_W{1'b1}})
      bar_count++;
    r.bar_no = bar_count;
    if (cfg_period <= 1) begin
      r.plus_dm = dm;
      return 1'b1;
    end
    if (int'(bar_count) > int'(cfg_period) - 1)
      dm_acc = dm_acc - dm_acc / {{(OUT_DM_W-CFG_W){1'b0}}, cfg_period};
    dm_acc = capped_sum(dm_acc, dm);
    r.plus_dm = dm_acc;
    return int'(bar_count) >= int'(cfg_period) + int'(cfg_unstable) - 1;
  endfunction

  // Driver: bursts of items with random gaps between them.
  int   burst_left = 0;
  int   gap_left   = 0;
  bar_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0 || bars_pending.size() == 0) begin
        if (gap_left > 0)
          gap_left--;
        s_tvalid <= 1'b0;
      end else begin
        nxt = bars_pending.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.start;
        s_tdata  <= {nxt.low, nxt.high};
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: own ready/stall runs, plus a long hold every HOLD_EVERY items.
  bit ready_phase = 1'b0;
  int run_left    = 0;
  int hold_left   = 0;
  int taken       = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        taken++;
        if (taken % HOLD_EVERY == 0)
          hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          ready_phase = !ready_phase || stall_max == 0;
          if (!ready_phase)
            run_left = $urandom_range(1, stall_max);
          else if ($urandom_range(0, 7) == 0)
            run_left = $urandom_range(50, 200);
          else
            run_left = $urandom_range(1, 24);
        end
        run_left--;
        m_tready <= ready_phase;
      end
    end
  end

  dm_out_t accepted_res;
  bar_t    accepted_bar;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      accepted_bar.start = s_tuser;
      accepted_bar.high  = s_tdata[PRICE_W-1:0];
      accepted_bar.low   = s_tdata[2*PRICE_W-1:PRICE_W];
      if (advance_series(accepted_bar, accepted_res))
        dm_expected.push_back(accepted_res);
    end
  end

  dm_out_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (dm_expected.size() == 0) begin
        fail_count++;
        $error("unexpected item: plus_dm %h bar_number %0d",
               m_tdata[OUT_DM_W-1:0], m_tdata[OUT_DATA_W-1:OUT_DM_W]);
      end else begin
        want = dm_expected.pop_front();
        if (m_tdata[OUT_DM_W-1:0] !== want.plus_dm) begin
          fail_count++;
          $error("plus_dm expected %h got %h", want.plus_dm, m_tdata[OUT_DM_W-1:0]);
        end
        if (m_tdata[OUT_DATA_W-1:OUT_DM_W] !== want.bar_no) begin
          fail_count++;
          $error("bar_number expected %0d got %0d", want.bar_no,
                 m_tdata[OUT_DATA_W-1:OUT_DM_W]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[plus_directional_movement_unit] ERROR");
      $finish;
    end
  end

  task automatic push_bar(input logic start, input logic [PRICE_W-1:0] hi,
                          input logic [PRICE_W-1:0] lo);
    bar_t b;
    b.start = start;
    b.high  = hi;
    b.low   = lo;
    bars_pending.push_back(b);
    bars_queued++;
  endtask

  task automatic push_series(input int len, input bit opened);
    logic [PRICE_W-1:0] hi, lo, span;
    span = 32'hFFFF_FFFF >> $urandom_range(0, 31);
    hi   = $urandom;
    lo   = hi - ($urandom & span);
    push_bar(opened, hi, lo);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 5) != 0)
        hi = $urandom_range(0, 1) ? hi + ($urandom & span) : hi - ($urandom & span);
      if ($urandom_range(0, 5) != 0)
        lo = $urandom_range(0, 1) ? lo + ($urandom & span) : lo - ($urandom & span);
      push_bar(1'b0, hi, lo);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_PERIOD)
      cfg_period = val;
    else
      cfg_unstable = val;
  endtask

  task automatic settle_idle();
    do @(negedge clk);
    while (bars_pending.size() != 0 || s_tvalid || dm_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int p, u, budget, len;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    gap_max   = 3;
    stall_max = 3;

    // Reset settings; first bar arrives with no series open.
    push_bar(1'b0, 32'h0064_0000, 32'h005A_0000);
    push_bar(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    push_bar(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
    push_bar(1'b0, 32'h0000_0010, 32'hFFFF_FFF0);
    push_bar(1'b0, 32'h0000_0020, 32'hFFFF_FFE0);
    push_bar(1'b0, 32'h0000_0030, 32'hFFFF_FFC0);
    push_bar(1'b0, 32'h0000_0030, 32'hFFFF_FFD0);
    for (int i = 1; i <= 9; i++)
      push_bar(1'b0, 32'h0000_0030 + i * 32'h0001_8000, 32'hFFFF_FF00 - i * 32'h10);
    push_bar(1'b1, 32'h1234_5678, 32'h1234_0000);
    push_bar(1'b0, 32'h1235_0000, 32'h1233_0000);
    settle_idle();

    // Period zero behaves as raw movement; unstable count ignored.
    write_reg(REG_PERIOD, '0);
    write_reg(REG_UNSTABLE, 12'd4095);
    push_bar(1'b1, 32'h0000_0000, 32'h0000_0000);
    push_bar(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_bar(1'b0, 32'h0000_0000, 32'h0000_0000);
    push_bar(1'b0, 32'h8000_0000, 32'h0000_0000);
    settle_idle();

    // Long unstable run keeps output suppressed.
    write_reg(REG_PERIOD, 12'd2);
    push_series(30, 1'b1);
    settle_idle();

    while (bars_queued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       p = 1;
        1:       p = 2;
        2:       p = $urandom_range(3, 8);
        3, 4:    p = $urandom_range(9, 40);
        default: p = $urandom_range(0, 1) ? 0 : $urandom_range(41, 100);
      endcase
      u = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      write_reg(REG_PERIOD, p[CFG_W-1:0]);
      write_reg(REG_UNSTABLE, u[CFG_W-1:0]);
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      budget = 0;
      while (budget < 250) begin
        if ($urandom_range(0, 7) == 0) begin
          push_bar(1'($urandom_range(0, 1)), $urandom, $urandom);
          budget++;
        end else begin
          len = $urandom_range(1, p + u + 30);
          push_series(len, $urandom_range(0, 9) != 0);
          budget += len;
        end
      end
      settle_idle();
    end

    // Widest period: accumulation only, no item.
    write_reg(REG_PERIOD, 12'd4095);
    write_reg(REG_UNSTABLE, '0);
    gap_max   = 1;
    stall_max = 2;
    push_series(200, 1'b1);
    settle_idle();

    // Raw series back to back with a large unstable count.
    write_reg(REG_PERIOD, 12'd1);
    write_reg(REG_UNSTABLE, 12'd4095);
    gap_max   = 0;
    stall_max = 0;
    push_series(200, 1'b1);
    settle_idle();

    if (fail_count == 0)
      $display("[plus_directional_movement_unit] OK");
    else
      $display("[plus_directional_movement_unit] ERROR");
    $finish;
  end

endmodule
